FILE: rtl/pirle_pkg.sv
`default_nettype none

package pirle_pkg;

  localparam int PALETTE_DEPTH = 254;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

  localparam logic [7:0]  MISS_INDEX     = 8'hFD;
  localparam logic [7:0]  SHORT_RUN_MARK = 8'hFF;
  localparam logic [7:0]  LONG_RUN_MARK  = 8'hFE;
  localparam logic [15:0] MAX_REPEAT     = 16'hFFFF;
  localparam logic [15:0] SHORT_RUN_LIM  = 16'd256;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } top_state_t;

  typedef enum logic {
    SR_IDLE,
    SR_SCAN
  } srch_state_t;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [15:0]       data;
  } pal_wr_t;

  typedef struct packed {
    logic             start;
    logic [15:0]      color;
    logic [CNT_W-1:0] limit;
  } srch_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] index;
  } srch_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/pirle_search.sv
`default_nettype none

module pirle_search (
  input  logic                  clk,
  input  logic                  rst,
  input  pirle_pkg::pal_wr_t    wr,
  input  pirle_pkg::srch_req_t  req,
  output pirle_pkg::srch_rsp_t  rsp
);
  import pirle_pkg::*;

  logic [15:0]       mem [PALETTE_DEPTH];
  srch_state_t       state, state_next;
  logic [CNT_W-1:0]  addr, addr_next;
  logic [CNT_W-1:0]  limit;
  logic [15:0]       key;
  logic [PAL_AW-1:0] rd_idx;
  logic [15:0]       rd_data;
  logic              rd_vld, rd_vld_next;
  logic              issue;
  logic              match;

  // palette storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue) begin
      rd_data <= mem[addr[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SR_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    if (issue) begin
      rd_idx <= addr[PAL_AW-1:0];
    end
    if (req.start && state == SR_IDLE) begin
      key   <= req.color;
      limit <= req.limit;
    end
  end

  always_comb begin
    state_next  = state;
    addr_next   = addr;
    issue       = 1'b0;
    rd_vld_next = 1'b0;
    rsp         = '0;
    match       = rd_vld && (rd_data == key);
    unique case (state)
      SR_IDLE: begin
        if (req.start) begin
          state_next = SR_SCAN;
          addr_next  = '0;
        end
      end
      SR_SCAN: begin
        if (match || addr >= limit) begin
          rsp.done   = 1'b1;
          rsp.index  = match ? 8'(rd_idx) : MISS_INDEX;
          state_next = SR_IDLE;
        end else begin
          issue       = 1'b1;
          rd_vld_next = 1'b1;
          addr_next   = CNT_W'(addr + 1'b1);
        end
      end
      default: begin
        state_next = SR_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/palette_index_rle_encoder.sv
// load word: accepted without a stall, no output
// pixel word: palette scan of min(palette_size, 254) entries, then one output byte
//   per cycle while out_stall is low (up to 4); next word accepted the cycle after the
//   last byte is loaded
// flush word: one pending run byte per cycle while out_stall is low, next word accepted after the last is loaded
// rst is synchronous: clears run state, palette_size and output valid; palette ram is not cleared
`default_nettype none

module palette_index_rle_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  palette_slot,
  input  logic [15:0] color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  palette_size
);
  import pirle_pkg::*;

  top_state_t       state, state_next;
  logic [7:0]       size_reg;
  logic [7:0]       prev_index, prev_index_next;
  logic             prev_valid, prev_valid_next;
  logic [15:0]      repeat_count, repeat_count_next;
  logic [7:0]       emit_buf [4];
  logic [7:0]       emit_buf_next [4];
  logic [2:0]       emit_cnt, emit_cnt_next;
  logic [1:0]       emit_pos, emit_pos_next;
  logic             out_valid_next;
  logic [7:0]       out_byte_next;
  logic             last_next;
  logic             in_acc;
  logic             run_short;
  logic [15:0]      rc_inc;
  logic [CNT_W-1:0] limit;
  pal_wr_t          wr;
  srch_req_t        req;
  srch_rsp_t        rsp;

  pirle_search u_search (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .req (req),
    .rsp (rsp)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign run_short = repeat_count < SHORT_RUN_LIM;
  assign rc_inc    = repeat_count + 16'd1;
  assign limit     = (size_reg > 8'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                    : CNT_W'(size_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      size_reg     <= '0;
      prev_index   <= '0;
      prev_valid   <= 1'b0;
      repeat_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      prev_index   <= prev_index_next;
      prev_valid   <= prev_valid_next;
      repeat_count <= repeat_count_next;
      out_valid    <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        size_reg <= palette_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_buf <= emit_buf_next;
    emit_cnt <= emit_cnt_next;
    emit_pos <= emit_pos_next;
    out_byte <= out_byte_next;
    last     <= last_next;
  end

  always_comb begin
    state_next        = state;
    prev_index_next   = prev_index;
    prev_valid_next   = prev_valid;
    repeat_count_next = repeat_count;
    emit_buf_next     = emit_buf;
    emit_cnt_next     = emit_cnt;
    emit_pos_next     = emit_pos;
    out_byte_next     = out_byte;
    last_next         = last;
    out_valid_next    = out_valid && out_stall;
    wr.we             = 1'b0;
    wr.addr           = palette_slot[PAL_AW-1:0];
    wr.data           = color;
    req.start         = 1'b0;
    req.color         = color;
    req.limit         = limit;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action)
            ACT_LOAD: begin
              wr.we = (palette_slot < 8'(PALETTE_DEPTH));
            end
            ACT_PIXEL: begin
              req.start  = 1'b1;
              state_next = ST_LOOKUP;
            end
            ACT_FLUSH: begin
              if (repeat_count != '0) begin
                emit_buf_next[0] = run_short ? SHORT_RUN_MARK : LONG_RUN_MARK;
                emit_buf_next[1] = repeat_count[7:0];
                emit_buf_next[2] = repeat_count[15:8];
                emit_cnt_next    = run_short ? 3'd2 : 3'd3;
                emit_pos_next    = '0;
                state_next       = ST_EMIT;
              end
              repeat_count_next = '0;
              prev_valid_next   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (rsp.done) begin
          emit_pos_next = '0;
          if (!prev_valid || rsp.index != prev_index) begin
            if (repeat_count != '0) begin
              emit_buf_next[0] = run_short ? SHORT_RUN_MARK : LONG_RUN_MARK;
              emit_buf_next[1] = repeat_count[7:0];
              if (run_short) begin
                emit_buf_next[2] = rsp.index;
                emit_cnt_next    = 3'd3;
              end else begin
                emit_buf_next[2] = repeat_count[15:8];
                emit_buf_next[3] = rsp.index;
                emit_cnt_next    = 3'd4;
              end
            end else begin
              emit_buf_next[0] = rsp.index;
              emit_cnt_next    = 3'd1;
            end
            repeat_count_next = '0;
            prev_index_next   = rsp.index;
            prev_valid_next   = 1'b1;
            state_next        = ST_EMIT;
          end else if (rc_inc == MAX_REPEAT) begin
            emit_buf_next[0]  = LONG_RUN_MARK;
            emit_buf_next[1]  = MAX_REPEAT[7:0];
            emit_buf_next[2]  = MAX_REPEAT[15:8];
            emit_cnt_next     = 3'd3;
            repeat_count_next = '0;
            prev_valid_next   = 1'b0;
            state_next        = ST_EMIT;
          end else begin
            repeat_count_next = rc_inc;
            state_next        = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_byte_next  = emit_buf[emit_pos];
          last_next      = ({1'b0, emit_pos} == emit_cnt - 3'd1);
          emit_pos_next  = emit_pos + 2'd1;
          if ({1'b0, emit_pos} == emit_cnt - 3'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/pirle_checker.sv
`default_nettype none

module pirle_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        last
);
  import pirle_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("output word changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // load and unused words give no output
  a_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid &&
    (action == ACT_LOAD || action == ACT_NONE) |=> !out_valid)
    else $error("output from a silent word");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_PIXEL |=> in_stall)
    else $error("pixel accepted without lookup");

  // bytes of one item leave back to back
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside an output burst");

endmodule

bind palette_index_rle_encoder pirle_checker u_chk (.*);

`default_nettype wire
